// ----- hw/rtl/tcep_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcep_pkg: text color escape parser definitions
// Byte codes, result kinds, stack command types and the hex digit decoder.
// ----------------------------------------------------------------------------
package tcep_pkg;

  localparam int TCEP_STACK_DEPTH = 32;

  localparam logic [7:0] BELL_BYTE = 8'h07;
  localparam logic [7:0] CASE_MASK = 8'hdf;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_U      = 8'h55;
  localparam logic [7:0] CH_O      = 8'h4f;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] HEX_TEN   = 8'd10;

  localparam logic [1:0] KIND_CHAR      = 2'd0;
  localparam logic [1:0] KIND_OVERFLOW  = 2'd1;
  localparam logic [1:0] KIND_UNDERFLOW = 2'd2;

  // request from the parser to the color stack
  typedef struct packed {
    logic rd;    // fetch top entry into the read register
    logic push;
    logic pop;
  } stk_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stk_status_t;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c >= CH_0 && c <= CH_9) begin
        v = c - CH_0;
        hex_decode = {1'b1, v[3:0]};
      end else if (c >= CH_UC_A && c <= CH_UC_F) begin
        v = c - CH_UC_A + HEX_TEN;
        hex_decode = {1'b1, v[3:0]};
      end else if (c >= CH_LC_A && c <= CH_LC_F) begin
        v = c - CH_LC_A + HEX_TEN;
        hex_decode = {1'b1, v[3:0]};
      end else begin
        hex_decode = {1'b0, v[3:0]};
      end
    end
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tcep_color_stack.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcep_color_stack: color pair stack
// Synchronous memory with registered read data plus the fill level counter.
// ----------------------------------------------------------------------------
module tcep_color_stack
  import tcep_pkg::*;
#(
  parameter int STACK_DEPTH = TCEP_STACK_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire stk_cmd_t    cmd,
  input  wire logic [7:0]  wr_data,
  output logic      [7:0]  rd_data,
  output stk_status_t      status
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [7:0]    mem [STACK_DEPTH];
  logic [7:0]    rd_data_r;
  logic [LW-1:0] level_r;
  logic [LW-1:0] level_nxt;
  logic [LW-1:0] level_m1;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign level_m1     = level_r - LW'(1);
  assign wr_addr      = level_r[AW-1:0];
  assign rd_addr      = level_m1[AW-1:0];
  assign status.full  = (level_r == LW'(STACK_DEPTH));
  assign status.empty = (level_r == '0);
  assign rd_data      = rd_data_r;

  always_comb begin
    level_nxt = level_r;
    if (cmd.push) begin
      level_nxt = level_r + LW'(1);
    end else if (cmd.pop) begin
      level_nxt = level_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/text_color_escape_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_color_escape_parser: byte stream color escape decoder
// Passes text bytes tagged with colors; bell codes set colors or push/pop
// the color pair on a stack held in a synchronous memory.
// ----------------------------------------------------------------------------
// A result is captured in the output register as its byte transfers.
// Throughput: one byte per cycle while not stalled; output frees on transfer.
// The stack top is fetched from memory when the first code byte transfers,
// so a pop has its data ready by the second code byte.
// Reset: synchronous rst_n clears parser state, colors (fg 7, bg 0), the
//   stack level and the output valid; stack memory contents are not cleared.
// ----------------------------------------------------------------------------
module text_color_escape_parser
  import tcep_pkg::*;
#(
  parameter int STACK_DEPTH = TCEP_STACK_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_last_in_string,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [1:0] out_result_kind,
  output logic      [7:0] out_char_out,
  output logic      [3:0] out_fg_color,
  output logic      [3:0] out_bg_color
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_SECOND
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [3:0]  fg_r, fg_nxt;
  logic [3:0]  bg_r, bg_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r;
  logic [7:0]  char_r;
  logic [3:0]  ofg_r;
  logic [3:0]  obg_r;

  logic        in_xfer;
  logic        out_xfer;
  logic        emit;
  logic [1:0]  emit_kind;
  logic [7:0]  emit_char;
  logic [7:0]  code_b;
  logic        is_stack_cmd;
  logic [4:0]  hex_a;
  logic [4:0]  hex_b;
  stk_cmd_t    stk_cmd;
  stk_status_t stk_status;
  logic [7:0]  stk_rd_data;

  assign out_xfer     = out_valid_r && !out_stall;
  assign in_stall     = out_valid_r && out_stall;
  assign in_xfer      = in_valid && !in_stall;
  assign code_b       = in_char_in & CASE_MASK;
  assign is_stack_cmd = ((first_r & CASE_MASK) == CH_P);
  assign hex_a        = hex_decode(first_r);
  assign hex_b        = hex_decode(in_char_in);

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_char_out    = char_r;
  assign out_fg_color    = ofg_r;
  assign out_bg_color    = obg_r;

  tcep_color_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (stk_cmd),
    .wr_data ({fg_r, bg_r}),
    .rd_data (stk_rd_data),
    .status  (stk_status)
  );

  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    fg_nxt    = fg_r;
    bg_nxt    = bg_r;
    emit      = 1'b0;
    emit_kind = KIND_CHAR;
    emit_char = 8'd0;
    stk_cmd   = '0;
    if (in_xfer) begin
      case (phase_r)
        PH_FIRST: begin
          first_nxt   = in_char_in;
          phase_nxt   = in_last_in_string ? PH_IDLE : PH_SECOND;
          stk_cmd.rd  = 1'b1;
        end
        PH_SECOND: begin
          phase_nxt = PH_IDLE;
          if (is_stack_cmd) begin
            if (code_b == CH_U) begin
              if (stk_status.full) begin
                emit      = 1'b1;
                emit_kind = KIND_OVERFLOW;
              end else begin
                stk_cmd.push = 1'b1;
              end
            end else if (code_b == CH_O) begin
              if (stk_status.empty) begin
                emit      = 1'b1;
                emit_kind = KIND_UNDERFLOW;
              end else begin
                stk_cmd.pop = 1'b1;
                fg_nxt      = stk_rd_data[7:4];
                bg_nxt      = stk_rd_data[3:0];
              end
            end
          end else begin
            if (hex_a[4]) begin
              bg_nxt = hex_a[3:0];
            end
            if (hex_b[4]) begin
              fg_nxt = hex_b[3:0];
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (in_char_in == BELL_BYTE) begin
            phase_nxt = in_last_in_string ? PH_IDLE : PH_FIRST;
          end else begin
            emit      = 1'b1;
            emit_kind = KIND_CHAR;
            emit_char = in_char_in;
          end
        end
      endcase
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      fg_r        <= 4'd7;
      bg_r        <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    first_r <= first_nxt;
    if (emit) begin
      kind_r <= emit_kind;
      char_r <= emit_char;
      ofg_r  <= fg_r;
      obg_r  <= bg_r;
    end
  end

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(stk_cmd.push && stk_cmd.pop))
    else $error("stack push and pop together");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cmd.pop |-> !stk_status.empty)
    else $error("pop on empty stack");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cmd.push |-> !stk_status.full)
    else $error("push on full stack");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_xfer))
    else $error("pending result overwritten");

  a_pop_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (stk_cmd.pop || stk_cmd.push) |-> (phase_r == PH_SECOND))
    else $error("stack access outside second code byte");

endmodule
`default_nettype wire
